// ===== src/assert_macros.svh =====
// Assertion macros shared by the frequency meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/icfm_pkg.sv =====
// Shared types and constants of the input-capture frequency meter.
package icfm_pkg;

    localparam int FREQ_W   = 28;  // frequency and clock rate width
    localparam int CAP_W    = 16;  // captured count field width
    localparam int PERIOD_W = 16;  // timer period register width
    localparam int OVF_W    = 16;  // saturating overflow count width
    localparam int IVL_W    = 32;  // interval width, modulo 2^32
    localparam int QCNT_W   = 5;   // divider step counter width

    localparam logic [FREQ_W-1:0]   FREQ_RESET   = 28'd45000000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;

    // Configuration register indexes
    localparam logic CFG_CLOCK_FREQUENCY = 1'b0;
    localparam logic CFG_TIMER_PERIOD    = 1'b1;

    // Event kinds
    localparam logic KIND_OVERFLOW = 1'b0;
    localparam logic KIND_CAPTURE  = 1'b1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } icfm_div_stat_t;

endpackage

// ===== src/icfm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module icfm_div
    import icfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FREQ_W-1:0]    dividend,
    input  logic [IVL_W-1:0]     divisor,
    output logic [FREQ_W-1:0]    quotient,
    output icfm_div_stat_t       stat
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [FREQ_W-1:0]   dvd_reg, dvd_next;
    logic [IVL_W-1:0]    rem_reg, rem_next;
    logic [IVL_W-1:0]    div_reg, div_next;
    logic [IVL_W:0]      trial;
    logic                fits;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, dvd_reg[FREQ_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = QCNT_W'(FREQ_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // Quotient bits fill the dividend register from the bottom
            dvd_next = {dvd_reg[FREQ_W-2:0], fits};
            rem_next = fits ? IVL_W'(trial - {1'b0, div_reg}) : trial[IVL_W-1:0];
            cnt_next = cnt_reg - QCNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== src/input_capture_frequency_meter.sv =====
// Top level of the input-capture frequency meter.
//
// Takes timer events on the input stream: an overflow event bumps a saturating
// overflow count, capture events alternate between a first edge (latch count,
// clear overflows) and a closing edge that yields one result: clock_frequency
// divided by the tick interval, or the previous frequency with the held flag
// set when the interval or quotient is zero. A closing edge runs the shift-add
// multiplier that adds overflows * (period + 1) to the interval, a zero check,
// the bit-serial divider, one quotient bit per clock frequency bit, and the
// output step; a zero interval skips the divider. The output step stretches
// while the output register still holds an unaccepted result. A finished
// result sits in the output register, so the next event is taken while it
// waits. Configuration is to be written only while idle, by the user; the
// block itself does not enforce it.
`include "assert_macros.svh"

module input_capture_frequency_meter
    import icfm_pkg::*;
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input events
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] captured_count
    input  logic [0:0]           s_axis_tuser,   // [0] kind
    // Results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [27:0] frequency_hz, [31:28] zero
    output logic [0:0]           m_axis_tuser,   // [0] held_flag
    // Configuration
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [FREQ_W-1:0]    cfg_wdata
);

    localparam int CNT_BITS = (COUNTER_BITS < CAP_W) ? COUNTER_BITS : CAP_W;
    localparam logic [CAP_W-1:0] CNT_MASK = CAP_W'((64'd1 << CNT_BITS) - 64'd1);

    logic [2:0]          state_reg, state_next;
    logic [FREQ_W-1:0]   clkfreq_reg, clkfreq_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                await_reg, await_next;
    logic [CAP_W-1:0]    first_reg, first_next;
    logic [OVF_W-1:0]    ovf_reg, ovf_next;
    logic [FREQ_W-1:0]   held_reg, held_next;
    logic                flag_reg, flag_next;
    logic [IVL_W-1:0]    acc_reg, acc_next;
    logic [IVL_W-1:0]    mcand_reg, mcand_next;
    logic [OVF_W-1:0]    mplier_reg, mplier_next;
    logic                oval_reg, oval_next;
    logic [FREQ_W-1:0]   ofreq_reg, ofreq_next;
    logic                oflag_reg, oflag_next;

    logic                in_xfer;
    logic [CAP_W-1:0]    cap_masked;
    logic                div_start;
    logic [FREQ_W-1:0]   div_quot;
    icfm_div_stat_t      div_stat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cap_masked    = s_axis_tdata & CNT_MASK;
    assign div_start     = (state_reg == ST_CHECK) && (acc_reg != '0);

    icfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (clkfreq_reg),
        .divisor  (acc_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Sequence events, the interval multiply and the result handoff
    always_comb
    begin
        state_next   = state_reg;
        clkfreq_next = clkfreq_reg;
        period_next  = period_reg;
        await_next   = await_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        held_next    = held_reg;
        flag_next    = flag_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        oval_next    = oval_reg;
        ofreq_next   = ofreq_reg;
        oflag_next   = oflag_reg;

        // Drop the result once the transaction completes
        if (oval_reg && m_axis_tready)
        begin
            oval_next = 1'b0;
        end

        // Write configuration
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_CLOCK_FREQUENCY: clkfreq_next = cfg_wdata;
                CFG_TIMER_PERIOD:    period_next  = cfg_wdata[PERIOD_W-1:0];
                default:             clkfreq_next = clkfreq_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser[0] == KIND_OVERFLOW)
                    begin
                        if (ovf_reg != '1)
                        begin
                            ovf_next = ovf_reg + OVF_W'(1);
                        end
                    end
                    else if (!await_reg)
                    begin
                        first_next = cap_masked;
                        ovf_next   = '0;
                        await_next = 1'b1;
                    end
                    else
                    begin
                        // On the closing edge, seed the interval with capture - first
                        await_next  = 1'b0;
                        acc_next    = IVL_W'(cap_masked) - IVL_W'(first_reg);
                        mcand_next  = IVL_W'({1'b0, period_reg & CNT_MASK}) + IVL_W'(1);
                        mplier_next = ovf_reg;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                // Add overflows * modulus one multiplier bit per cycle
                if (mplier_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[IVL_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[OVF_W-1:1]};
                end
            end
            ST_CHECK:
            begin
                // Zero interval keeps the old frequency
                if (acc_reg == '0)
                begin
                    flag_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_quot != '0)
                    begin
                        held_next = div_quot;
                        flag_next = 1'b0;
                    end
                    else
                    begin
                        flag_next = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // Load the output register once it is free
                if (!oval_reg || m_axis_tready)
                begin
                    oval_next  = 1'b1;
                    ofreq_next = held_reg;
                    oflag_next = flag_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control and architectural state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            clkfreq_reg <= FREQ_RESET;
            period_reg  <= PERIOD_RESET;
            await_reg   <= 1'b0;
            first_reg   <= '0;
            ovf_reg     <= '0;
            held_reg    <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clkfreq_reg <= clkfreq_next;
            period_reg  <= period_next;
            await_reg   <= await_next;
            first_reg   <= first_next;
            ovf_reg     <= ovf_next;
            held_reg    <= held_next;
            oval_reg    <= oval_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        flag_reg   <= flag_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        ofreq_reg  <= ofreq_next;
        oflag_reg  <= oflag_next;
    end

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = {{(32 - FREQ_W){1'b0}}, ofreq_reg};
    assign m_axis_tuser  = oflag_reg;

    // Divider runs only while the sequencer waits on it
    `ASSERT_IMPLIES(a_div_busy_in_div, clk, rst_n, div_stat.busy || div_stat.done,
        state_reg == ST_DIV)
    // A fresh frequency is never zero
    `ASSERT_IMPLIES(a_fresh_nonzero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0],
        m_axis_tdata[27:0] != 28'd0)
    // A pair in flight has already cleared the edge toggle
    `ASSERT_IMPLIES(a_busy_pair_closed, clk, rst_n, state_reg != ST_IDLE, !await_reg)
    // The pair-closing edge starts the multiply
    `ASSERT_NEXT(a_second_edge_mul, clk, rst_n,
        in_xfer && (s_axis_tuser[0] == KIND_CAPTURE) && await_reg, state_reg == ST_MUL)

endmodule
